// ===== hw/rtl/value_array_table_unit_defines.svh =====
// Assertion macros for the value array table unit.
// Included by the top level; no other dependencies.
`ifndef VALUE_ARRAY_TABLE_UNIT_DEFINES_SVH
`define VALUE_ARRAY_TABLE_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define VATU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define VATU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/vatu_pkg.sv =====
// Shared types and codes for the value array table unit.
// No dependencies.
`timescale 1ns / 1ps

package vatu_pkg;

   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int MASK_W   = 16;
   localparam int COUNT_W  = 5;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [MASK_W-1:0]   match_mask;
      logic [COUNT_W-1:0]  fill_count;
   } rsp_type;

endpackage

// ===== hw/rtl/value_array_table_unit.sv =====
// Value array table unit: top level joining the sequencer and the entry memory.
// Depends on vatu_pkg, vatu_ctrl, vatu_mem and value_array_table_unit_defines.svh.
//
//   channel  ports                 handshake
//   request  req_item              taken when start is high and busy is low
//   result   rsp_item              shown for one cycle with rsp_strobe high
//
// Insert: the result appears the cycle after the item is taken; busy stays low.
// Delete, update, search: busy while every filled entry is scanned; the result
// appears in the cycle that busy falls. On an empty table busy stays low and the
// result appears the cycle after the item is taken. The single read port of the
// entry memory, scanned one entry a cycle past one comparator, sets the scan length
// (delete shifts in the same pass).
// Reset clears the fill count and the control state; entries need no clearing.
// The result side cannot stall, so every result is delivered in its cycle.
`timescale 1ns / 1ps
`include "value_array_table_unit_defines.svh"

module value_array_table_unit
   import vatu_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              insert_taken;
   logic              fail_rsp;

   vatu_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   vatu_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // conditions watched by the checks
   assign insert_taken = start && !busy && (req_item.func == FUNC_INSERT);
   assign fail_rsp     = rsp_strobe && (rsp_item.status != ST_DONE);

   // insert answers on the very next cycle
   `VATU_ASSERT_NEXT(a_insert_next, clock, reset, insert_taken, rsp_strobe, "insert result late")
   // failed operations report no positions
   `VATU_ASSERT_SAME(a_fail_mask, clock, reset, fail_rsp, rsp_item.match_mask == '0, "mask on fail")
   // no result without an item in flight
   `VATU_ASSERT_NEXT(a_no_spurious, clock, reset, !busy && !start, !rsp_strobe, "stray result")
   // reads never run while idle
   `VATU_ASSERT_SAME(a_idle_no_read, clock, reset, !busy, !rd_en, "memory read while idle")

endmodule

// ===== hw/rtl/vatu_mem.sv =====
// Entry storage: one write port, one read port with registered read data.
// Depends on vatu_pkg for the data width.
`timescale 1ns / 1ps

module vatu_mem
   import vatu_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/vatu_ctrl.sv =====
// Operation sequencer: appends, scans, rewrites and compacts the entry memory.
// Depends on vatu_pkg; drives the ports of vatu_mem.
`timescale 1ns / 1ps

module vatu_ctrl
   import vatu_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int AW       = 4,
   parameter int CW       = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_item,
   output logic              rsp_strobe,
   output rsp_type           rsp_item,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output logic [DATA_W-1:0] wr_data,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   input  logic [DATA_W-1:0] rd_data
);

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_SCAN = 1'b1;

   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   logic [0:0]        state_ff, state_in;
   req_type           op_ff, op_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     issue_ff, issue_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic              hit_ff, hit_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_item_ff, rsp_item_in;
   logic [CW-1:0]     fill_after;

   // one-hot mask bit for a position; positions past the mask set nothing
   function automatic logic [MASK_W-1:0] pos_bit(input logic [AW-1:0] pos);
      logic [MASK_W-1:0] bits;
      bits = '0;
      for (int b = 0; b < MASK_W; b++) begin
         if (32'(pos) == 32'(b)) begin
            bits[b] = 1'b1;
         end
      end
      return bits;
   endfunction

   // Reads always run ahead of writes (update writes the compared entry,
   // delete writes one below it), so no access pair hits the same entry.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      fill_in       = fill_ff;
      issue_in      = issue_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      mask_in       = mask_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      rd_en         = 1'b0;
      rd_addr       = issue_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = op_ff.value;
      fill_after    = fill_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_item;
               issue_in = '0;
               hit_in   = 1'b0;
               mask_in  = '0;
               if (req_item.func == FUNC_INSERT) begin
                  // append at the fill position, or report full
                  rsp_strobe_in = 1'b1;
                  if (fill_ff == FULL_COUNT) begin
                     rsp_item_in.status     = ST_FULL;
                     rsp_item_in.match_mask = '0;
                     rsp_item_in.fill_count = COUNT_W'(fill_ff);
                  end else begin
                     wr_en      = 1'b1;
                     wr_addr    = fill_ff[AW-1:0];
                     wr_data    = req_item.value;
                     fill_after = fill_ff + 1'b1;
                     fill_in    = fill_after;
                     rsp_item_in.status     = ST_DONE;
                     rsp_item_in.match_mask = pos_bit(fill_ff[AW-1:0]);
                     rsp_item_in.fill_count = COUNT_W'(fill_after);
                  end
               end else if (fill_ff == '0) begin
                  // nothing to scan
                  rsp_strobe_in          = 1'b1;
                  rsp_item_in.status     = ST_NOTFOUND;
                  rsp_item_in.match_mask = '0;
                  rsp_item_in.fill_count = COUNT_W'(fill_ff);
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // issue the next read of the filled range
            if (issue_ff < fill_ff) begin
               rd_en        = 1'b1;
               issue_in     = issue_ff + 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = issue_ff[AW-1:0];
            end

            if (cmp_valid_ff) begin
               priority if (op_ff.func == FUNC_DELETE && hit_ff) begin
                  // shift the later entries down by one
                  wr_en   = 1'b1;
                  wr_addr = cmp_idx_ff - 1'b1;
                  wr_data = rd_data;
               end else if (rd_data == op_ff.value) begin
                  hit_in  = 1'b1;
                  mask_in = mask_ff | pos_bit(cmp_idx_ff);
                  if (op_ff.func == FUNC_UPDATE) begin
                     wr_en   = 1'b1;
                     wr_addr = cmp_idx_ff;
                     wr_data = op_ff.new_value;
                  end
               end else begin
                  // no match: hold the entry as it is
                  hit_in = hit_ff;
               end
            end else if (issue_ff >= fill_ff) begin
               // scan drained: report and drop back to idle
               if (op_ff.func == FUNC_DELETE && hit_ff) begin
                  fill_after = fill_ff - 1'b1;
               end
               fill_in                = fill_after;
               state_in               = S_IDLE;
               rsp_strobe_in          = 1'b1;
               rsp_item_in.status     = hit_ff ? ST_DONE : ST_NOTFOUND;
               rsp_item_in.match_mask = mask_ff;
               rsp_item_in.fill_count = COUNT_W'(fill_after);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         issue_ff      <= '0;
         cmp_valid_ff  <= 1'b0;
         hit_ff        <= 1'b0;
         mask_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         issue_ff      <= issue_in;
         cmp_valid_ff  <= cmp_valid_in;
         hit_ff        <= hit_in;
         mask_ff       <= mask_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      cmp_idx_ff  <= cmp_idx_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

// ===== test/value_array_table_unit_tb.sv =====
// Self-checking testbench for value_array_table_unit: insert, delete, update and search
// items against a local model of the table. Depends on vatu_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module value_array_table_unit_tb;
   import vatu_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 100;
   localparam int PHASE_COUNT = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // table model
   logic signed [DATA_W-1:0] table_entries [TABLE_DEPTH];
   int                       table_fill = 0;

   rsp_type pending_results [$];
   int      fail_count  = 0;
   int      cycle_count = 0;
   bit      no_idle     = 1'b0;
   logic signed [DATA_W-1:0] value_pool [8];

   value_array_table_unit #(.CAPACITY(TABLE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** value_array_table_unit: FAILED **");
         $finish;
      end
   end

   // Apply one item to the table model and return the result it should produce.
   function automatic rsp_type predict_table_op(req_type it);
      rsp_type r;
      bit      hit;
      int      i;
      int      j;
      r.status     = ST_DONE;
      r.match_mask = '0;
      hit          = 1'b0;
      case (it.func)
         FUNC_INSERT: begin
            if (table_fill >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               table_entries[table_fill] = it.value;
               if (table_fill < MASK_W) r.match_mask[table_fill] = 1'b1;
               table_fill++;
            end
         end
         FUNC_DELETE: begin
            for (i = 0; i < table_fill && !hit; i++) begin
               if (table_entries[i] == it.value) begin
                  if (i < MASK_W) r.match_mask[i] = 1'b1;
                  for (j = i; j + 1 < table_fill; j++) table_entries[j] = table_entries[j + 1];
                  hit = 1'b1;
               end
            end
            if (hit) table_fill--;
            else r.status = ST_NOTFOUND;
         end
         default: begin
            for (i = 0; i < table_fill; i++) begin
               if (table_entries[i] == it.value) begin
                  if (i < MASK_W) r.match_mask[i] = 1'b1;
                  hit = 1'b1;
                  if (it.func == FUNC_UPDATE) table_entries[i] = it.new_value;
               end
            end
            if (!hit) r.status = ST_NOTFOUND;
         end
      endcase
      r.fill_count = table_fill[COUNT_W-1:0];
      return r;
   endfunction

   // Send one item, idle first as drawn, and record its expected result once taken.
   task automatic issue_op(input logic [FUNC_W-1:0] op, input logic signed [DATA_W-1:0] val,
                           input logic signed [DATA_W-1:0] nval);
      req_type it;
      int      gap;
      it.func      = op;
      it.value     = val;
      it.new_value = nval;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_table_op(it));
   endtask

   // Hold off the sender until every expected result has come back.
   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Compare each result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d mask %h count %0d",
                   rsp_item.status, rsp_item.match_mask, rsp_item.fill_count);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.match_mask !== want.match_mask) begin
               $error("match_mask: expected %h, actual %h", want.match_mask, rsp_item.match_mask);
               fail_count++;
            end
            if (rsp_item.fill_count !== want.fill_count) begin
               $error("fill_count: expected %0d, actual %0d", want.fill_count, rsp_item.fill_count);
               fail_count++;
            end
         end
      end
   end

   // Every lookup on an empty table misses.
   task automatic test_empty_table();
      issue_op(FUNC_SEARCH, 32'sd0, 32'sd0);
      issue_op(FUNC_DELETE, 32'sd5, 32'sd0);
      issue_op(FUNC_UPDATE, -32'sd1, 32'sd7);
      wait_for_results();
   endtask

   // Extreme values, duplicates, update of all matches, delete with shift, miss.
   task automatic test_extremes();
      issue_op(FUNC_INSERT, 32'sh8000_0000, 32'sh7fff_ffff);
      issue_op(FUNC_INSERT, 32'sh7fff_ffff, 32'sh8000_0000);
      issue_op(FUNC_INSERT, 32'sd0, -32'sd1);
      issue_op(FUNC_INSERT, -32'sd1, 32'sd0);
      issue_op(FUNC_INSERT, 32'sh7fff_ffff, 32'sd0);
      issue_op(FUNC_SEARCH, 32'sh7fff_ffff, 32'sd0);
      issue_op(FUNC_UPDATE, 32'sh7fff_ffff, 32'sh8000_0000);
      issue_op(FUNC_DELETE, 32'sh8000_0000, 32'sd0);
      issue_op(FUNC_DELETE, 32'sh0001_2345, 32'sd0);
      wait_for_results();
   endtask

   // Fill the table, insert when full, match many positions, delete the last one.
   task automatic test_full_table();
      while (table_fill < TABLE_DEPTH - 1) issue_op(FUNC_INSERT, -32'sd1, 32'sd0);
      issue_op(FUNC_INSERT, 32'sh1234_5678, 32'sd0);
      issue_op(FUNC_INSERT, 32'sd3, 32'sd0);
      issue_op(FUNC_SEARCH, -32'sd1, 32'sd0);
      issue_op(FUNC_DELETE, 32'sh1234_5678, 32'sd0);
      wait_for_results();
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value(bit noisy);
      if (noisy || $urandom_range(0, 3) == 0) return $urandom;
      return value_pool[$urandom_range(0, 7)];
   endfunction

   // Random items in phases that push the table toward full and back toward empty.
   task automatic test_random_ops();
      int                  phase;
      int                  n;
      int                  roll;
      int                  ins_pct;
      bit                  noisy;
      logic [FUNC_W-1:0]   op;
      value_pool[0] = 32'sd0;
      value_pool[1] = -32'sd1;
      value_pool[2] = 32'sh8000_0000;
      value_pool[3] = 32'sh7fff_ffff;
      for (n = 4; n < 8; n++) value_pool[n] = $urandom;
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         ins_pct = phase[0] ? 12 : 55;
         noisy   = (phase == 5);
         no_idle = (phase == 2 || phase == 6);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct) op = FUNC_INSERT;
            else if (roll < ins_pct + (100 - ins_pct) / 2) op = FUNC_DELETE;
            else if ($urandom_range(0, 1) == 0) op = FUNC_UPDATE;
            else op = FUNC_SEARCH;
            issue_op(op, pick_value(noisy), pick_value(noisy));
         end
         if (phase == 3) wait_for_results();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_extremes();
      test_full_table();
      test_random_ops();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4 * TABLE_DEPTH) @(posedge clock);
      if (fail_count == 0) begin
         $display("** value_array_table_unit: PASSED **");
      end else begin
         $display("** value_array_table_unit: FAILED **");
      end
      $finish;
   end

endmodule
